// ===== hdl/fctg_pkg.sv =====
// Package for the floor/ceiling texel coordinate generator.
// Payload structs, field widths and shared constants; no dependencies.
`default_nettype none
package fctg_pkg;
  localparam int SCREEN_BITS      = 11;
  localparam int TEX_LOG2_MAX_DEF = 10;
  localparam int DIST_W           = 24;
  localparam int POS_W            = 26;
  localparam int FE_W             = 15;
  localparam int DIR_W            = 16;
  localparam int SCALE_NUM        = 83;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [2:0] REG_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_PLAYER_X = 3'd1;
  localparam logic [2:0] REG_PLAYER_Y = 3'd2;
  localparam logic [2:0] REG_FLOOR_W  = 3'd3;
  localparam logic [2:0] REG_FLOOR_H  = 3'd4;
  localparam logic [2:0] REG_CEIL_W   = 3'd5;
  localparam logic [2:0] REG_CEIL_H   = 3'd6;

  typedef struct packed {
    logic                func;
    logic [10:0]         column;
    logic [10:0]         row;
    logic [10:0]         wall_half;
    logic [FE_W-1:0]     fisheye;
    logic signed [15:0]  dir_cos;
    logic signed [15:0]  dir_sin;
  } in_item_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [10:0] out_row;
    logic        covered;
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic        dist_saturated;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/fctg_front.sv =====
// Front end: classifies a pixel as covered or not and forms the division denominator.
// Depends on fctg_pkg.
`default_nettype none
module fctg_front import fctg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   acc,
  input  wire in_item_t               item,
  input  wire logic [SCREEN_BITS:0]   height,
  output logic                        vld_r,
  output logic                        func_r,
  output logic [10:0]                 col_r,
  output logic [10:0]                 row_r,
  output logic                        cov_r,
  output logic                        sat_r,
  output logic [SCREEN_BITS+FE_W:0]   den_r,
  output logic signed [15:0]          dc_r,
  output logic signed [15:0]          ds_r
);
  localparam int SW = SCREEN_BITS;
  logic [SW-1:0] r, wh;
  logic signed [SW+3:0] hh, half, rr, d;
  logic cov_nxt;
  always_comb begin
    r    = item.row[SW-1:0];
    wh   = item.wall_half[SW-1:0];
    hh   = $signed({3'b0, height});
    half = hh >>> 1;
    rr   = $signed({4'b0, r});
    if (item.func) begin
      cov_nxt = rr + $signed({4'b0, wh}) <= half;
      d = hh - (rr <<< 1);
    end else begin
      cov_nxt = (rr >= half + $signed({4'b0, wh})) && (rr < hh);
      d = (rr <<< 1) - hh;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= acc;
    func_r <= item.func;
    row_r  <= item.row;
    col_r  <= item.column;
    cov_r  <= cov_nxt;
    sat_r  <= (d <= 0) || (item.fisheye == '0);
    den_r  <= (d <= 0) ? '0 : (SW+FE_W+1)'(d[SW:0] * item.fisheye);
    dc_r   <= item.dir_cos;
    ds_r   <= item.dir_sin;
  end
endmodule
`default_nettype wire

// ===== hdl/fctg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^24-1.
// Depends on fctg_pkg; carries a side word alongside each operation.
`default_nettype none
module fctg_div import fctg_pkg::*; #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 27,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_vld,
  output logic [DIST_W-1:0]      quot,
  output logic                   ovf,
  output logic [SIDE_W-1:0]      side_out
);
  // Quotient above 2^24-1 iff num >= den<<24; check first, then 24 bit stages.
  localparam int ST = DIST_W + 1;
  localparam int RW = DEN_W + 1;
  logic              v_r   [ST];
  logic [NUM_W-1:0]  n_r   [ST];
  logic [DEN_W-1:0]  d_r   [ST];
  logic [RW-1:0]     rem_r [ST];
  logic [DIST_W-1:0] q_r   [ST];
  logic              o_r   [ST];
  logic [SIDE_W-1:0] s_r   [ST];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= in_vld;
    n_r[0]   <= num;
    d_r[0]   <= den;
    rem_r[0] <= RW'(num >> DIST_W);
    q_r[0]   <= '0;
    o_r[0]   <= (den == '0) || ((num >> DIST_W) >= NUM_W'(den));
    s_r[0]   <= side_in;
  end

  for (genvar i = 1; i < ST; i++) begin : g_st
    logic [RW-1:0] tr;
    logic          ge;
    always_comb begin
      tr = {rem_r[i-1][RW-2:0], n_r[i-1][DIST_W-i]};
      ge = tr >= {1'b0, d_r[i-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= v_r[i-1];
      n_r[i]   <= n_r[i-1];
      d_r[i]   <= d_r[i-1];
      rem_r[i] <= ge ? tr - {1'b0, d_r[i-1]} : tr;
      q_r[i]   <= {q_r[i-1][DIST_W-2:0], ge};
      o_r[i]   <= o_r[i-1];
      s_r[i]   <= s_r[i-1];
    end
  end
  assign out_vld  = v_r[ST-1];
  assign quot     = o_r[ST-1] ? {DIST_W{1'b1}} : q_r[ST-1];
  assign ovf      = o_r[ST-1];
  assign side_out = s_r[ST-1];
endmodule
`default_nettype wire

// ===== hdl/fctg_back.sv =====
// Back end: queue after the divider, then position step and texel extraction.
// Depends on fctg_pkg; two pipeline stages after the queue.
`default_nettype none
module fctg_back import fctg_pkg::*; #(
  parameter int TEX_LOG2_MAX = TEX_LOG2_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [DIST_W-1:0] distance,
  input  wire logic              sat,
  input  wire logic              func,
  input  wire logic              cov,
  input  wire logic [10:0]       col,
  input  wire logic [10:0]       row,
  input  wire logic signed [15:0] dc,
  input  wire logic signed [15:0] ds,
  input  wire logic [POS_W-1:0]  px,
  input  wire logic [POS_W-1:0]  py,
  input  wire logic [3:0]        fw, fh, cw, ch,
  output logic                   out_strobe_r,
  output out_item_t              out_r
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic sat, func, cov;
    logic [10:0] col, row;
    logic signed [15:0] dc, ds;
  } qent_t;
  qent_t q_mem [QUEUE_DEPTH];
  logic [QW:0] wp_r, rp_r;
  logic pop;
  qent_t e;
  // Consumer never stalls, so drain one entry each cycle while the queue is not empty.
  assign pop = wp_r != rp_r;
  always_ff @(posedge clk) begin
    if (in_vld) q_mem[wp_r[QW-1:0]] <= {distance, sat, func, cov, col, row, dc, ds};
    e <= q_mem[rp_r[QW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0;
    end else begin
      if (in_vld) wp_r <= wp_r + 1'b1;
      if (pop)    rp_r <= rp_r + 1'b1;
    end
  end
  logic v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= pop;
  end

  logic signed [41:0] mx_r, my_r;
  qent_t e2_r;
  logic v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    mx_r <= $signed({1'b0, e.distance}) * e.dc;
    my_r <= $signed({1'b0, e.distance}) * e.ds;
    e2_r <= e;
  end

  function automatic logic [9:0] texel(input logic [POS_W-1:0] p, input logic [3:0] lw);
    logic [4:0] l;
    logic [POS_W-1:0] s;
    l = (lw > 4'(TEX_LOG2_MAX)) ? 5'(TEX_LOG2_MAX) : {1'b0, lw};
    if (l > 5'd16) l = 5'd16;
    s = (p >> (5'd16 - l)) & ((POS_W'(1) << l) - 1'b1);
    return s[9:0];
  endfunction

  logic [POS_W-1:0] pxs, pys;
  always_comb begin
    pxs = px + POS_W'(mx_r >>> 14);
    pys = py + POS_W'(my_r >>> 14);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= v2_r;
    out_r.out_column     <= e2_r.col;
    out_r.out_row        <= e2_r.row;
    out_r.covered        <= e2_r.cov;
    out_r.texel_x        <= e2_r.cov ? texel(pxs, e2_r.func ? cw : fw) : '0;
    out_r.texel_y        <= e2_r.cov ? texel(pys, e2_r.func ? ch : fh) : '0;
    out_r.dist_saturated <= e2_r.cov & e2_r.sat;
  end
endmodule
`default_nettype wire

// ===== hdl/floor_ceiling_texcoord_gen.sv =====
// Top level of the floor/ceiling texel coordinate generator.
// Depends on fctg_pkg, fctg_front, fctg_div and fctg_back.
//
// Usage: drive in_item with start high; the item is taken on any edge where busy
// is low. busy stays low, so one pixel is accepted every clock that start is high.
// Each result appears on out_item for one cycle with out_strobe high. After the
// accepting edge it passes the classification register (loaded at that edge),
// 25 divider stages, the queue write and read, a multiply stage and the output
// register. Throughput is one item per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no pixel is in flight. Unknown indices drop.
// Reset (synchronous, rst_n low) empties the pipeline and loads register
// defaults: height 480, player at 0, all texture sizes 64.
// The receiver cannot stall; results are dropped if not taken.
`default_nettype none
module floor_ceiling_texcoord_gen import fctg_pkg::*; #(
  parameter int TEX_LOG2_MAX = TEX_LOG2_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int DEN_W = SCREEN_BITS + FE_W + 1;
  localparam int NUM_W = SCREEN_BITS + 1 + 7 + DIST_W;

  logic [SCREEN_BITS:0] height_r;
  logic [POS_W-1:0] px_r, py_r;
  logic [3:0] fw_r, fh_r, cw_r, ch_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= (SCREEN_BITS+1)'(480);
      px_r <= '0; py_r <= '0;
      fw_r <= 4'd6; fh_r <= 4'd6; cw_r <= 4'd6; ch_r <= 4'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEIGHT:   height_r <= cfg_data[SCREEN_BITS:0];
        REG_PLAYER_X: px_r <= cfg_data[POS_W-1:0];
        REG_PLAYER_Y: py_r <= cfg_data[POS_W-1:0];
        REG_FLOOR_W:  fw_r <= cfg_data[3:0];
        REG_FLOOR_H:  fh_r <= cfg_data[3:0];
        REG_CEIL_W:   cw_r <= cfg_data[3:0];
        REG_CEIL_H:   ch_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic f_vld, f_func, f_cov, f_sat;
  logic [10:0] f_col, f_row;
  logic [DEN_W-1:0] f_den;
  logic signed [15:0] f_dc, f_ds;

  fctg_front u_front (
    .clk, .rst_n, .acc(start && !busy), .item(in_item), .height(height_r),
    .vld_r(f_vld), .func_r(f_func), .col_r(f_col), .row_r(f_row),
    .cov_r(f_cov), .sat_r(f_sat), .den_r(f_den), .dc_r(f_dc), .ds_r(f_ds)
  );

  localparam int SIDE_W = 1 + 1 + 1 + 22 + 32;
  logic [NUM_W-1:0] num;
  assign num = NUM_W'(height_r * 7'd83) << DIST_W;

  logic d_vld, d_ovf;
  logic [DIST_W-1:0] d_q;
  logic [SIDE_W-1:0] d_side;
  fctg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_div (
    .clk, .rst_n, .in_vld(f_vld), .num(num), .den(f_den),
    .side_in({f_sat, f_func, f_cov, f_col, f_row, f_dc, f_ds}),
    .out_vld(d_vld), .quot(d_q), .ovf(d_ovf), .side_out(d_side)
  );

  logic s_sat;
  assign s_sat = d_side[SIDE_W-1] | d_ovf;

  fctg_back #(.TEX_LOG2_MAX(TEX_LOG2_MAX)) u_back (
    .clk, .rst_n, .in_vld(d_vld),
    .distance(d_side[SIDE_W-1] ? {DIST_W{1'b1}} : d_q), .sat(s_sat),
    .func(d_side[SIDE_W-2]), .cov(d_side[SIDE_W-3]),
    .col(d_side[53:43]), .row(d_side[42:32]),
    .dc(d_side[31:16]), .ds(d_side[15:0]),
    .px(px_r), .py(py_r), .fw(fw_r), .fh(fh_r), .cw(cw_r), .ch(ch_r),
    .out_strobe_r(out_strobe), .out_r(out_item)
  );
endmodule
`default_nettype wire

// ===== hdl/fctg_checker.sv =====
// Port-level checker for the texel coordinate generator, bound to the top level.
// Depends on fctg_pkg.
`default_nettype none
module fctg_checker import fctg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      busy,
  input wire logic      out_strobe,
  input wire out_item_t out_item
);
  a_no_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
  a_sat_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.dist_saturated |-> out_item.covered) else $error("sat uncovered");
  a_tex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.covered |-> out_item.texel_x == '0 && out_item.texel_y == '0)
    else $error("texel set on uncovered pixel");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe) else $error("strobe after reset");
endmodule

bind floor_ceiling_texcoord_gen fctg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_strobe(out_strobe), .out_item(out_item)
);
`default_nettype wire
